@@ hw/rtl/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg: shared types and constants for the TGA RLE pixel decoder
// Register indexes, field widths and the pixel beat passed from the packet
// unpacker to the top level.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BPP_W     = 3;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned HELD_W    = 24;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL     = 1'd1;

    // Pixel sizes and reset values
    localparam logic [BPP_W-1:0]   BPP_32BIT       = 3'd4;
    localparam logic [BPP_W-1:0]   BPP_RESET       = 3'd4;
    localparam logic [COUNT_W-1:0] PIX_TOTAL_RESET = 32'd1;

    // Last byte position of a pixel
    localparam logic [1:0] LAST_POS_24 = 2'd2;
    localparam logic [1:0] LAST_POS_32 = 2'd3;

    // Repeat packet headers carry count+127
    localparam logic [BYTE_W-1:0] REPEAT_BIAS = 8'd127;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] run;
    } pix_evt_t;

endpackage

@@ hw/rtl/tgarle_unpack.sv @@
// ----------------------------------------------------------------------------
// tgarle_unpack: packet header and pixel byte tracker
// Parses packet headers, gathers pixel bytes and flags the beat that
// completes a pixel, together with its channels and run length.
// ----------------------------------------------------------------------------
module tgarle_unpack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_go,
    input  logic [tgarle_pkg::BYTE_W-1:0] data_byte,
    input  logic [tgarle_pkg::BPP_W-1:0]  bytes_per_pixel,
    output tgarle_pkg::pix_evt_t          evt
);
    import tgarle_pkg::*;

    logic              expect_header_reg, expect_header_next;
    logic              repeat_reg, repeat_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [1:0]        pos_reg, pos_next;
    logic [HELD_W-1:0] held_reg, held_next;

    logic [1:0]        last_pos;
    logic [BYTE_W-1:0] left_dec;

    assign last_pos = (bytes_per_pixel == BPP_32BIT) ? LAST_POS_32 : LAST_POS_24;
    assign left_dec = left_reg - 8'd1;

    always_comb begin
        expect_header_next = expect_header_reg;
        repeat_next        = repeat_reg;
        left_next          = left_reg;
        pos_next           = pos_reg;
        held_next          = held_reg;
        evt                = '0;
        evt.blue           = held_reg[7:0];
        evt.green          = held_reg[15:8];
        if (last_pos == LAST_POS_32) begin
            evt.red   = held_reg[23:16];
            evt.alpha = data_byte;
        end else begin
            evt.red   = data_byte;
            evt.alpha = '0;
        end
        evt.run = repeat_reg ? left_reg : 8'd1;

        if (byte_go) begin
            if (expect_header_reg) begin
                repeat_next        = data_byte[7];
                left_next          = data_byte[7] ? (data_byte - REPEAT_BIAS)
                                                  : (data_byte + 8'd1);
                expect_header_next = 1'b0;
                pos_next           = '0;
                held_next          = '0;
            end else if (pos_reg < last_pos) begin
                // gather a byte before the last one of the pixel
                case (pos_reg)
                    2'd0:    held_next[7:0]   = data_byte;
                    2'd1:    held_next[15:8]  = data_byte;
                    2'd2:    held_next[23:16] = data_byte;
                    default: held_next        = held_reg;
                endcase
                pos_next = pos_reg + 2'd1;
            end else begin
                evt.fire  = 1'b1;
                pos_next  = '0;
                held_next = '0;
                if (repeat_reg) begin
                    left_next          = '0;
                    expect_header_next = 1'b1;
                end else begin
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        expect_header_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            repeat_reg        <= 1'b0;
            left_reg          <= '0;
            pos_reg           <= '0;
            held_reg          <= '0;
        end else begin
            expect_header_reg <= expect_header_next;
            repeat_reg        <= repeat_next;
            left_reg          <= left_next;
            pos_reg           <= pos_next;
            held_reg          <= held_next;
        end
    end

    // A packet body always has at least one pixel to go
    a_body_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        !expect_header_reg |-> left_reg != '0)
        else $error("packet body with zero pixels left");

endmodule

@@ hw/rtl/tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: run-length TGA pixel stream decoder
// Turns the byte stream of run-length TGA packets into pixel beats with run
// lengths, counted against the configured image size.
// ----------------------------------------------------------------------------
// The decoder takes one stream byte per cycle on s_data_byte while s_ready
// is high and emits one beat per complete pixel on the m_ channel, with blue
// and red already put in their own ports and a run length of 1 for literal
// pixels or the repeat count (1..128) for a repeat packet; repeats are never
// expanded. Pixels are 3 or 4 bytes (register 0, any value other than 4
// means 3; alpha reads zero for 3-byte pixels). Register 1 holds the pixel
// total: the beat that reaches it carries m_image_last, and m_overrun as
// well if its run goes past it. After that beat every byte is taken and
// dropped until reset. Throughput is one byte per cycle: each byte is
// handled by a short update of the packet tracker plus one 33-bit add and
// compare on the pixel count, and the result lands in an output register
// that s_ready keeps free as long as the consumer drains it. Each pixel's
// beat is registered. Write configuration only while the decoder is idle.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tgarle_pkg::BYTE_W-1:0]     s_data_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tgarle_pkg::BYTE_W-1:0]     m_red,
    output logic [tgarle_pkg::BYTE_W-1:0]     m_green,
    output logic [tgarle_pkg::BYTE_W-1:0]     m_blue,
    output logic [tgarle_pkg::BYTE_W-1:0]     m_alpha,
    output logic [tgarle_pkg::BYTE_W-1:0]     m_run_length,
    output logic                              m_image_last,
    output logic                              m_overrun,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgarle_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import tgarle_pkg::*;

    // Configuration registers
    logic [BPP_W-1:0]   bpp_reg;
    logic [COUNT_W-1:0] total_reg;

    // Image progress
    logic [COUNT_W-1:0] pixels_done_reg, pixels_done_next;
    logic               image_complete_reg, image_complete_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_red_reg, m_green_reg, m_blue_reg, m_alpha_reg, m_run_length_reg;
    logic               m_image_last_reg, m_overrun_reg;

    logic               in_beat;
    logic               byte_go;
    pix_evt_t           evt;
    logic [COUNT_W:0]   sum;
    logic               hit_total;
    logic               past_total;

    // Take a byte whenever the output register is empty or being drained
    assign s_ready   = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;
    // Drop every byte once the image is complete
    assign byte_go   = in_beat && !image_complete_reg;

    tgarle_unpack u_unpack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_go         (byte_go),
        .data_byte       (s_data_byte),
        .bytes_per_pixel (bpp_reg),
        .evt             (evt)
    );

    // Count pixels with the unsaturated sum, saturate the stored count
    assign sum        = {1'b0, pixels_done_reg} + {{(COUNT_W + 1 - BYTE_W){1'b0}}, evt.run};
    assign hit_total  = sum >= {1'b0, total_reg};
    assign past_total = sum >  {1'b0, total_reg};

    always_comb begin
        pixels_done_next    = pixels_done_reg;
        image_complete_next = image_complete_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        if (evt.fire) begin
            pixels_done_next = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            m_valid_next     = 1'b1;
            if (hit_total) begin
                image_complete_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg            <= BPP_RESET;
            total_reg          <= PIX_TOTAL_RESET;
            pixels_done_reg    <= '0;
            image_complete_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BYTES_PER_PIXEL: bpp_reg   <= cfg_data[BPP_W-1:0];
                    REG_PIXEL_TOTAL:     total_reg <= cfg_data[COUNT_W-1:0];
                    default:             bpp_reg   <= bpp_reg;
                endcase
            end
            pixels_done_reg    <= pixels_done_next;
            image_complete_reg <= image_complete_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // Load the result payload with each completed pixel
    always_ff @(posedge aclk) begin
        if (evt.fire) begin
            m_red_reg        <= evt.red;
            m_green_reg      <= evt.green;
            m_blue_reg       <= evt.blue;
            m_alpha_reg      <= evt.alpha;
            m_run_length_reg <= evt.run;
            m_image_last_reg <= hit_total;
            m_overrun_reg    <= past_total;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = m_red_reg;
    assign m_green      = m_green_reg;
    assign m_blue       = m_blue_reg;
    assign m_alpha      = m_alpha_reg;
    assign m_run_length = m_run_length_reg;
    assign m_image_last = m_image_last_reg;
    assign m_overrun    = m_overrun_reg;

    // No new beat appears once the image is complete
    a_quiet_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        image_complete_reg && !m_valid_reg |=> !m_valid_reg)
        else $error("result produced after image completion");

    // An overrun beat is always the last beat of the image
    a_overrun_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_overrun_reg |-> m_image_last_reg)
        else $error("overrun without image_last");

    // Runs are never empty
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_run_length_reg != '0)
        else $error("zero run length");

    // The last beat leaves the image marked complete
    a_last_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_image_last_reg |-> image_complete_reg)
        else $error("image_last beat without completion");

    // The pixel count never goes backward outside reset
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> pixels_done_reg >= $past(pixels_done_reg))
        else $error("pixel count decreased");

endmodule

@@ sim/tga_pixel_beat_checker.sv @@
// ----------------------------------------------------------------------------
// tga_pixel_beat_checker: pixel beat predictor and scoreboard
// Watches the byte, pixel and register channels of the TGA RLE decoder,
// decodes every accepted byte with its own packet tracker and compares each
// pixel beat, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module tga_pixel_beat_checker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [tgarle_pkg::BYTE_W-1:0]       s_data_byte,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [tgarle_pkg::BYTE_W-1:0]       m_red,
    input  logic [tgarle_pkg::BYTE_W-1:0]       m_green,
    input  logic [tgarle_pkg::BYTE_W-1:0]       m_blue,
    input  logic [tgarle_pkg::BYTE_W-1:0]       m_alpha,
    input  logic [tgarle_pkg::BYTE_W-1:0]       m_run_length,
    input  logic                                m_image_last,
    input  logic                                m_overrun,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tgarle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgarle_pkg::CFG_DAT_W-1:0]    cfg_data,

    output int                                  fail_count,
    output int                                  pending,
    output logic [tgarle_pkg::COUNT_W-1:0]      pixels_counted,
    output logic                                image_done
);
    import tgarle_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] run_length;
        logic              image_last;
        logic              overrun;
    } pixel_beat_t;

    pixel_beat_t expected_pixels[$];

    logic [BPP_W-1:0]   bpp_cfg;
    logic [COUNT_W-1:0] total_cfg;
    logic               want_header;
    logic               is_repeat;
    logic [BYTE_W-1:0]  pix_left;
    logic [1:0]         byte_pos;
    logic [HELD_W-1:0]  held;
    int                 beat_index;
    logic               image_complete;

    assign image_done = image_complete;

    // One stream byte through the packet tracker; push a beat when a pixel ends
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [1:0]        last_pos;
        logic [BYTE_W-1:0] run;
        logic [COUNT_W:0]  sum;
        pixel_beat_t       beat;
        last_pos = (bpp_cfg == BPP_32BIT) ? LAST_POS_32 : LAST_POS_24;
        if (image_complete)
            return;
        if (want_header) begin
            is_repeat   = b[7];
            pix_left    = b[7] ? b - REPEAT_BIAS : b + 8'd1;
            want_header = 1'b0;
            byte_pos    = '0;
            held        = '0;
            return;
        end
        if (byte_pos < last_pos) begin
            held     = held | (HELD_W'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return;
        end
        beat.blue  = held[7:0];
        beat.green = held[15:8];
        if (last_pos == LAST_POS_32) begin
            beat.red   = held[23:16];
            beat.alpha = b;
        end else begin
            beat.red   = b;
            beat.alpha = '0;
        end
        run = is_repeat ? pix_left : 8'd1;
        // compare on the full sum, store the count saturated
        sum = {1'b0, pixels_counted} + (COUNT_W + 1)'(run);
        pixels_counted  = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        beat.run_length = run;
        beat.image_last = (sum >= {1'b0, total_cfg});
        beat.overrun    = (sum > {1'b0, total_cfg});
        expected_pixels.push_back(beat);
        byte_pos = '0;
        held     = '0;
        if (is_repeat) begin
            pix_left    = '0;
            want_header = 1'b1;
        end else begin
            pix_left = pix_left - 8'd1;
            if (pix_left == '0)
                want_header = 1'b1;
        end
        if (beat.image_last)
            image_complete = 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            if (fail_count < 10)
                $display("pixel beat %0d, %s: expected %0d, got %0d",
                         beat_index, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_beat_t want;
        if (!aresetn) begin
            bpp_cfg        = BPP_RESET;
            total_cfg      = PIX_TOTAL_RESET;
            want_header    = 1'b1;
            is_repeat      = 1'b0;
            pix_left       = '0;
            byte_pos       = '0;
            held           = '0;
            pixels_counted = '0;
            image_complete = 1'b0;
            beat_index     = 0;
            fail_count     = 0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_BYTES_PER_PIXEL)
                    bpp_cfg = cfg_data[BPP_W-1:0];
                else if (cfg_index == REG_PIXEL_TOTAL)
                    total_cfg = cfg_data;
            end
            // check the outgoing beat before this edge's byte can add a new one
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    if (fail_count < 10)
                        $display("pixel beat %0d: none expected, got r=%0d g=%0d b=%0d",
                                 beat_index, m_red, m_green, m_blue);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.red, m_red);
                    check_field("green", want.green, m_green);
                    check_field("blue", want.blue, m_blue);
                    check_field("alpha", want.alpha, m_alpha);
                    check_field("run_length", want.run_length, m_run_length);
                    check_field("image_last", BYTE_W'(want.image_last),
                                BYTE_W'(m_image_last));
                    check_field("overrun", BYTE_W'(want.overrun), BYTE_W'(m_overrun));
                end
                beat_index++;
            end
            if (s_valid && s_ready)
                decode_byte(s_data_byte);
        end
        pending = expected_pixels.size();
    end

endmodule

@@ sim/tb_tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder: testbench for the TGA RLE pixel decoder
// Feeds hand-picked packets and then random packet streams, with noise and
// cut-off packets, under changing pixel sizes and totals; a checker beside
// the decoder predicts every pixel beat. The run ends by driving the image
// to completion and sending trailing bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;

    import tgarle_pkg::*;

    localparam logic [COUNT_W-1:0] TOTAL_MAX      = 32'd4294836225;
    localparam logic [COUNT_W-1:0] TOTAL_SAFE_MIN = 32'd1000000;
    localparam int                 RANDOM_END     = 440;  // bytes before the calm tail
    localparam int                 RX_HOLD_CYCLES = 150;
    localparam int                 SETTLE_CYCLES  = 4;
    localparam int                 WATCHDOG_LIMIT = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BYTE_W-1:0]    m_red;
    logic [BYTE_W-1:0]    m_green;
    logic [BYTE_W-1:0]    m_blue;
    logic [BYTE_W-1:0]    m_alpha;
    logic [BYTE_W-1:0]    m_run_length;
    logic                 m_image_last;
    logic                 m_overrun;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int                   fail_count;
    int                   pending;
    logic [COUNT_W-1:0]   pixels_counted;
    logic                 image_done;

    // Stimulus knobs shared by the sender and receiver processes
    int                   tx_gap_pct = 0;
    bit                   tail_calm = 1'b0;
    bit                   hold_req = 1'b0;
    int                   bytes_sent = 0;
    int                   quiet_cycles = 0;

    tga_rle_pixel_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_run_length (m_run_length),
        .m_image_last (m_image_last),
        .m_overrun    (m_overrun),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tga_pixel_beat_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_run_length   (m_run_length),
        .m_image_last   (m_image_last),
        .m_overrun      (m_overrun),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_counted (pixels_counted),
        .image_done     (image_done)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: end the run when no channel moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts whose density is redrawn every 64 decisions,
    // one long hold on request, and no stalls in the calm tail
    initial begin
        int stall_pct;
        int mode_left;
        stall_pct = 0;
        mode_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                mode_left = 64;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            mode_left--;
            if (hold_req) begin
                // hold off long enough for the decoder to fill and push back
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
                hold_req = 1'b0;
            end else if (!tail_calm && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one stream byte, maybe after an idle burst; return on acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every predicted beat has left the decoder
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the pixel size, and the pixel total when asked, as back-to-back beats
    task automatic configure(input logic [BPP_W-1:0] bpp, input logic [COUNT_W-1:0] total,
                             input bit write_total);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BYTES_PER_PIXEL;
        cfg_data  <= CFG_DAT_W'(bpp);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (write_total) begin
            cfg_index <= REG_PIXEL_TOTAL;
            cfg_data  <= total;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // One packet: mostly well formed, sometimes cut short, sometimes plain noise
    task automatic send_packet(input int pixel_size);
        int count;
        int payload;
        int cut;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 1) == 1) begin
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            send_byte(BYTE_W'(count + 127));
            payload = pixel_size;
        end else begin
            count = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 128) : $urandom_range(1, 8);
            send_byte(BYTE_W'(count - 1));
            payload = count * pixel_size;
        end
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, payload - 1) : payload;
        repeat (cut) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int               phase;
        int               pixel_size;
        int               tries;
        logic [BPP_W-1:0] bpp;
        logic [COUNT_W-1:0] total;
        phase = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 32-bit pixels, total far out of reach
        configure(BPP_32BIT, TOTAL_MAX, 1'b1);
        // repeat packet of 128 with alternating extreme channels
        send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
        // literal packet of one all-ones pixel
        send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
        // repeat of 4, stop one byte short of the 32-bit pixel
        send_byte(8'h83);
        send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
        wait_idle();
        // shrink the pixel mid-pixel: the next byte ends it as red
        configure(3'd3, TOTAL_MAX, 1'b0);
        send_byte(8'h44);
        // repeat of one, 24-bit pixel
        send_byte(8'h80);
        send_byte(8'hAA); send_byte(8'h55); send_byte(8'h5A);
        wait_idle();
        // odd pixel size behaves as 24-bit; literal of two
        configure(3'd7, TOTAL_MAX, 1'b0);
        send_byte(8'h01);
        send_byte(8'h01); send_byte(8'h02); send_byte(8'h04);
        send_byte(8'h08); send_byte(8'h10); send_byte(8'h20);

        // Random phases: new size and total at each idle boundary
        while (bytes_sent < RANDOM_END) begin
            phase++;
            wait_idle();
            case ($urandom_range(0, 5))
                0, 1, 2: bpp = BPP_32BIT;
                3, 4:    bpp = 3'd3;
                default: bpp = BPP_W'($urandom_range(0, 7));
            endcase
            total = ($urandom_range(0, 2) == 0) ? TOTAL_MAX
                                                : $urandom_range(TOTAL_SAFE_MIN, TOTAL_MAX);
            configure(bpp, total, 1'b1);
            pixel_size = (bpp == BPP_32BIT) ? 4 : 3;
            case ($urandom_range(0, 2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 5;
                default: tx_gap_pct = 25;
            endcase
            // long receiver hold while the sender keeps pushing
            if (phase == 3)
                hold_req = 1'b1;
            repeat ($urandom_range(2, 12)) send_packet(pixel_size);
        end

        // Calm tail: bring the image to completion, then feed bytes to drop
        wait_idle();
        tx_gap_pct = 0;
        tail_calm  = 1'b1;
        bpp        = ($urandom_range(0, 1) == 1) ? BPP_32BIT : 3'd3;
        pixel_size = (bpp == BPP_32BIT) ? 4 : 3;
        case ($urandom_range(0, 2))
            0: total = '0;                                    // first pixel overruns
            1: total = pixels_counted + $urandom_range(1, 12); // reached inside a packet
            default: total = 32'd1;                           // already passed
        endcase
        configure(bpp, total, 1'b1);
        tries = 0;
        while (!image_done && tries < 40) begin
            send_packet(pixel_size);
            tries++;
        end
        repeat (20) send_byte(BYTE_W'($urandom_range(0, 255)));
        wait_idle();

        if (pending != 0)
            $display("%0d predicted pixel beats never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
